// ===== sv/tche_pkg.sv =====
// Package for the thermal contact heat exchange block.
// Holds widths, register indexes, status codes and the transfer structs.
// No dependencies.
package tche_pkg;

    localparam int NUM_MATERIALS = 4;
    localparam int SLOTS         = 4;

    localparam int MASS_W  = 16;
    localparam int TEMP_W  = 16;
    localparam int CP_W    = 16;
    localparam int INV_W   = 32;
    localparam int ACT_W   = 3;
    localparam int RATE_W  = 32;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    localparam int MC_W    = MASS_W + CP_W;
    localparam int TMC_W   = MC_W + TEMP_W;
    localparam int DEN_W   = MC_W + 2;
    localparam int NUM_W   = TMC_W + 2;
    localparam int QUO_W   = TEMP_W + 8;
    localparam int PROD_W  = QUO_W + INV_W;

    localparam int DIV_STAGES = QUO_W;
    localparam int SIDE_DEPTH = DIV_STAGES + 4;
    localparam int LATENCY    = DIV_STAGES + 7;

    localparam logic [IDX_W-1:0] REG_HC0    = 3'd0;
    localparam logic [IDX_W-1:0] REG_HC1    = 3'd1;
    localparam logic [IDX_W-1:0] REG_HC2    = 3'd2;
    localparam logic [IDX_W-1:0] REG_HC3    = 3'd3;
    localparam logic [IDX_W-1:0] REG_INV_TS = 3'd4;
    localparam logic [IDX_W-1:0] REG_ACTIVE = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [MASS_W-1:0] mass_0;
        logic [MASS_W-1:0] mass_1;
        logic [MASS_W-1:0] mass_2;
        logic [MASS_W-1:0] mass_3;
        logic [TEMP_W-1:0] temp_0;
        logic [TEMP_W-1:0] temp_1;
        logic [TEMP_W-1:0] temp_2;
        logic [TEMP_W-1:0] temp_3;
    } node_in_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_0;
        logic signed [RATE_W-1:0] rate_1;
        logic signed [RATE_W-1:0] rate_2;
        logic signed [RATE_W-1:0] rate_3;
        logic [STAT_W-1:0]        status;
    } node_out_t;

    typedef struct packed {
        logic [SLOTS-1:0]             mask;
        logic [SLOTS-1:0][TEMP_W-1:0] temp;
    } side_t;

endpackage

// ===== sv/tche_lane_front.sv =====
// Front half of one material lane: heat capacity m*Cp and weighted T*m*Cp.
// Two register stages. Depends on tche_pkg.
module tche_lane_front (
    input  logic                         clk,
    input  logic [tche_pkg::MASS_W-1:0]  mass,
    input  logic [tche_pkg::TEMP_W-1:0]  temp,
    input  logic [tche_pkg::CP_W-1:0]    cp,
    input  logic                         act,
    output logic [tche_pkg::MC_W-1:0]    mc,
    output logic [tche_pkg::TMC_W-1:0]   tmc
);
    import tche_pkg::*;

    logic [MC_W-1:0]   mc1_reg;
    logic [TEMP_W-1:0] temp1_reg;
    logic [MC_W-1:0]   mc2_reg;
    logic [TMC_W-1:0]  tmc2_reg;

    always_ff @(posedge clk)
    begin
        mc1_reg   <= act ? MC_W'(mass) * MC_W'(cp) : '0;
        temp1_reg <= temp;
        mc2_reg   <= mc1_reg;
        tmc2_reg  <= TMC_W'(temp1_reg) * TMC_W'(mc1_reg);
    end

    assign mc  = mc2_reg;
    assign tmc = tmc2_reg;

endmodule

// ===== sv/tche_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 256 / den) when that fits the quotient. Depends on tche_pkg.
module tche_div (
    input  logic                        clk,
    input  logic [tche_pkg::NUM_W-1:0]  num,
    input  logic [tche_pkg::DEN_W-1:0]  den,
    output logic [tche_pkg::QUO_W-1:0]  quo
);
    import tche_pkg::*;

    logic [DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [QUO_W-1:0] low_reg [DIV_STAGES];
    logic [QUO_W-1:0] q_reg   [DIV_STAGES];
    logic [DEN_W-1:0] d_reg   [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [DEN_W-1:0] rem_in;
            logic [QUO_W-1:0] low_in;
            logic [QUO_W-1:0] q_in;
            logic [DEN_W-1:0] d_in;
            logic [DEN_W:0]   trial;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign rem_in = num[NUM_W-1 -: DEN_W];
                assign low_in = {num[NUM_W-DEN_W-1:0], 8'd0};
                assign q_in   = '0;
                assign d_in   = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign d_in   = d_reg[k-1];
            end

            assign trial = {rem_in, low_in[QUO_W-1]};
            assign ge    = trial >= {1'b0, d_in};

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
                low_reg[k] <= {low_in[QUO_W-2:0], 1'b0};
                q_reg[k]   <= {q_in[QUO_W-2:0], ge};
                d_reg[k]   <= d_in;
            end
        end
    endgenerate

    assign quo = q_reg[DIV_STAGES-1];

endmodule

// ===== sv/tche_lane_rate.sv =====
// Back half of one material lane: difference to the contact temperature,
// scaling by the reciprocal step and saturation. Depends on tche_pkg.
module tche_lane_rate (
    input  logic                               clk,
    input  logic [tche_pkg::QUO_W-1:0]         contact,
    input  logic [tche_pkg::TEMP_W-1:0]        temp,
    input  logic [tche_pkg::INV_W-1:0]         inv_ts,
    input  logic                               act,
    input  logic                               zero,
    output logic signed [tche_pkg::RATE_W-1:0] rate,
    output logic                               sat
);
    import tche_pkg::*;

    localparam int P_W = PROD_W - 16;

    logic [QUO_W-1:0]  own;
    logic [QUO_W-1:0]  mag_reg;
    logic              neg_reg;
    logic              use_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg2_reg;
    logic              use2_reg;
    logic [P_W-1:0]    p;
    logic              over;

    assign own = {temp, 8'd0};

    always_ff @(posedge clk)
    begin
        mag_reg  <= (contact >= own) ? contact - own : own - contact;
        neg_reg  <= contact < own;
        use_reg  <= act && !zero;
        prod_reg <= PROD_W'(mag_reg) * PROD_W'(inv_ts);
        neg2_reg <= neg_reg;
        use2_reg <= use_reg;
    end

    always_comb
    begin
        p = prod_reg[PROD_W-1:16];
        if (!neg2_reg)
        begin
            over = p[P_W-1:RATE_W-1] != '0;
        end
        else
        begin
            over = p > P_W'(64'h8000_0000);
        end
        sat = use2_reg && over;
        if (!use2_reg)
        begin
            rate = '0;
        end
        else if (!neg2_reg)
        begin
            rate = over ? RATE_W'(32'h7FFF_FFFF) : p[RATE_W-1:0];
        end
        else
        begin
            rate = over ? RATE_W'(32'h8000_0000) : RATE_W'(~p[RATE_W-1:0] + 1'b1);
        end
    end

endmodule

// ===== sv/thermal_contact_heat_exchange_top.sv =====
// Top level of the thermal contact heat exchange block: configuration
// registers, lanes, merging sums, divider and result register. Uses tche_pkg.
//
//  channel   handshake               payload
//  input     start, busy             in_data  (node_in_t)
//  result    done (strobe)           result   (node_out_t)
//  config    cfg_we                  cfg_index, cfg_data
//
// One node enters every cycle; busy is always low.
// Each result reaches the ports, together with done, through the input register,
// two front stages, the sums, the 24-stage divider, two rate stages and the
// result register.
// Reset clears the valid line and loads the register defaults.
// The receiver cannot stall; results are shown for one cycle.
module thermal_contact_heat_exchange_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tche_pkg::node_in_t           in_data,
    output logic                         done,
    output tche_pkg::node_out_t          result,
    input  logic                         cfg_we,
    input  logic [tche_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tche_pkg::DATA_W-1:0]  cfg_data
);
    import tche_pkg::*;

    logic [SLOTS-1:0][CP_W-1:0] cp_reg;
    logic [INV_W-1:0]           inv_reg;
    logic [ACT_W-1:0]           active_reg;
    logic [LATENCY-1:0]         valid_reg;
    node_in_t                   in_reg;
    side_t                      side_reg [SIDE_DEPTH];
    logic                       zero_reg [DIV_STAGES];
    logic [DEN_W-1:0]           den_reg;
    logic [NUM_W-1:0]           num_reg;
    node_out_t                  result_reg;

    logic [SLOTS-1:0]             mask;
    logic [SLOTS-1:0][TEMP_W-1:0] in_temp;
    logic [SLOTS-1:0][MASS_W-1:0] mass;
    logic [SLOTS-1:0][MC_W-1:0]   mc;
    logic [SLOTS-1:0][TMC_W-1:0]  tmc;
    logic [SLOTS-1:0][RATE_W-1:0] rate;
    logic [SLOTS-1:0]             sat;
    logic [QUO_W-1:0]             contact;
    logic                         accept;
    side_t                        side_end;
    logic                         zero_end;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg     <= {SLOTS{CP_W'(256)}};
            inv_reg    <= INV_W'(65536);
            active_reg <= ACT_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HC0:    cp_reg[0]  <= cfg_data[CP_W-1:0];
                REG_HC1:    cp_reg[1]  <= cfg_data[CP_W-1:0];
                REG_HC2:    cp_reg[2]  <= cfg_data[CP_W-1:0];
                REG_HC3:    cp_reg[3]  <= cfg_data[CP_W-1:0];
                REG_INV_TS: inv_reg    <= cfg_data[INV_W-1:0];
                REG_ACTIVE: active_reg <= cfg_data[ACT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
        end
    end

    assign in_temp = {in_data.temp_3, in_data.temp_2, in_data.temp_1, in_data.temp_0};
    assign mass    = {in_reg.mass_3, in_reg.mass_2, in_reg.mass_1, in_reg.mass_0};

    genvar i;
    generate
        for (i = 0; i < SLOTS; i++)
        begin : g_mask
            if (i < NUM_MATERIALS)
            begin : g_on
                assign mask[i] = active_reg > ACT_W'(i);
            end
            else
            begin : g_off
                assign mask[i] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        in_reg           <= in_data;
        side_reg[0].mask <= mask;
        side_reg[0].temp <= in_temp;
        for (int s = 1; s < SIDE_DEPTH; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
        zero_reg[0] <= den_reg == '0;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            zero_reg[s] <= zero_reg[s-1];
        end
        den_reg <= DEN_W'(mc[0]) + DEN_W'(mc[1]) + DEN_W'(mc[2]) + DEN_W'(mc[3]);
        num_reg <= NUM_W'(tmc[0]) + NUM_W'(tmc[1]) + NUM_W'(tmc[2]) + NUM_W'(tmc[3]);
    end

    assign side_end = side_reg[SIDE_DEPTH-1];
    assign zero_end = zero_reg[DIV_STAGES-1];

    generate
        for (i = 0; i < SLOTS; i++)
        begin : g_lane
            if (i < NUM_MATERIALS)
            begin : g_on
                tche_lane_front u_front (
                    .clk  (clk),
                    .mass (mass[i]),
                    .temp (side_reg[0].temp[i]),
                    .cp   (cp_reg[i]),
                    .act  (side_reg[0].mask[i]),
                    .mc   (mc[i]),
                    .tmc  (tmc[i])
                );
                tche_lane_rate u_rate (
                    .clk     (clk),
                    .contact (contact),
                    .temp    (side_end.temp[i]),
                    .inv_ts  (inv_reg),
                    .act     (side_end.mask[i]),
                    .zero    (zero_end),
                    .rate    (rate[i]),
                    .sat     (sat[i])
                );
            end
            else
            begin : g_off
                assign mc[i]   = '0;
                assign tmc[i]  = '0;
                assign rate[i] = '0;
                assign sat[i]  = 1'b0;
            end
        end
    endgenerate

    tche_div u_div (
        .clk (clk),
        .num (num_reg),
        .den (den_reg),
        .quo (contact)
    );

    logic zero_d1_reg;
    logic zero_d2_reg;

    always_ff @(posedge clk)
    begin
        zero_d1_reg       <= zero_end;
        zero_d2_reg       <= zero_d1_reg;
        result_reg.rate_0 <= rate[0];
        result_reg.rate_1 <= rate[1];
        result_reg.rate_2 <= rate[2];
        result_reg.rate_3 <= rate[3];
        if (zero_d2_reg)
        begin
            result_reg.status <= ST_ZERO;
        end
        else if (sat != '0)
        begin
            result_reg.status <= ST_SAT;
        end
        else
        begin
            result_reg.status <= ST_OK;
        end
    end

    assign done   = valid_reg[LATENCY-1];
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("result strobe missing after transfer");

    a_zero_rates: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_ZERO |->
            result.rate_0 == '0 && result.rate_1 == '0 &&
            result.rate_2 == '0 && result.rate_3 == '0)
        else $error("nonzero rate with zero heat capacity");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status == ST_OK || result.status == ST_ZERO ||
                 result.status == ST_SAT)
        else $error("undefined status code");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for thermal_contact_heat_exchange_top: random and directed nodes
// checked against a mixture-temperature predictor. Depends on tche_pkg and the top.
module tb;
    import tche_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    node_in_t in_data = '0;
    logic done;
    node_out_t result;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    thermal_contact_heat_exchange_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [15:0] cp [SLOTS];
    logic [31:0] inv_ts;
    logic [2:0] active;

    node_in_t pending_nodes[$];
    node_out_t expected_rates[$];
    int send_idle_pct = 0;
    int errors = 0;
    int nodes_sent = 0;
    int results_seen = 0;
    longint cycle = 0;

    function automatic node_out_t mixture_rates(node_in_t n);
        logic [15:0] m [SLOTS];
        logic [15:0] t [SLOTS];
        logic [63:0] num, den, contact, own, mag, p, mc;
        logic [31:0] r [SLOTS];
        int cnt;
        bit sat;
        node_out_t o;
        m[0] = n.mass_0; m[1] = n.mass_1; m[2] = n.mass_2; m[3] = n.mass_3;
        t[0] = n.temp_0; t[1] = n.temp_1; t[2] = n.temp_2; t[3] = n.temp_3;
        cnt = (active > NUM_MATERIALS) ? NUM_MATERIALS : int'(active);
        num = 0; den = 0; sat = 0;
        for (int i = 0; i < SLOTS; i++) r[i] = '0;
        for (int i = 0; i < cnt; i++)
        begin
            mc = 64'(m[i]) * 64'(cp[i]);
            den += mc;
            num += 64'(t[i]) * mc;
        end
        if (den == 0)
        begin
            o = '0;
            o.status = ST_ZERO;
            return o;
        end
        contact = (num << 8) / den;
        for (int i = 0; i < cnt; i++)
        begin
            own = 64'(t[i]) << 8;
            mag = (contact >= own) ? contact - own : own - contact;
            p = (mag * 64'(inv_ts)) >> 16;
            if (contact >= own)
            begin
                if (p > 64'h7FFF_FFFF) begin p = 64'h7FFF_FFFF; sat = 1; end
                r[i] = p[31:0];
            end
            else
            begin
                if (p > 64'h8000_0000) begin p = 64'h8000_0000; sat = 1; end
                r[i] = 32'(0 - p);
            end
        end
        o.rate_0 = r[0]; o.rate_1 = r[1]; o.rate_2 = r[2]; o.rate_3 = r[3];
        o.status = sat ? ST_SAT : ST_OK;
        return o;
    endfunction

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_rates.push_back(mixture_rates(in_data));
                void'(pending_nodes.pop_front());
                nodes_sent <= nodes_sent + 1;
            end
            if ((!start || !busy) ? 1'b1 : 1'b1)
            begin
                if (pending_nodes.size() > ((start && !busy) ? 0 : 0) &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    start <= (pending_nodes.size() != 0);
                    if (pending_nodes.size() != 0) in_data <= pending_nodes[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        node_out_t e;
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (expected_rates.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                e = expected_rates.pop_front();
                if (e.rate_0 !== result.rate_0 || e.rate_1 !== result.rate_1 ||
                    e.rate_2 !== result.rate_2 || e.rate_3 !== result.rate_3 ||
                    e.status !== result.status)
                begin
                    $display("%0t: mismatch expected %h %h %h %h st %0d, actual %h %h %h %h st %0d",
                        $time, e.rate_0, e.rate_1, e.rate_2, e.rate_3, e.status,
                        result.rate_0, result.rate_1, result.rate_2, result.rate_3,
                        result.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle > 400000)
        begin
            $display("** thermal_contact_heat_exchange_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < 4) cp[idx] = val[15:0];
        else if (idx == REG_INV_TS) inv_ts = val;
        else if (idx == REG_ACTIVE) active = val[2:0];
    endtask

    task automatic drain_results();
        while (pending_nodes.size() != 0 || start || expected_rates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic node_in_t random_node(int mode);
        node_in_t n;
        n = {$urandom, $urandom, $urandom, $urandom};
        if (mode == 1)
        begin
            n.mass_0 &= 16'h0FFF; n.temp_0 = 16'(4000 + $urandom_range(2000));
            n.temp_1 = 16'(4000 + $urandom_range(2000));
            n.temp_2 = 16'(4000 + $urandom_range(2000));
            n.temp_3 = 16'(4000 + $urandom_range(2000));
        end
        else if (mode == 2)
        begin
            if ($urandom_range(1)) n.mass_0 = 0;
            if ($urandom_range(1)) n.mass_1 = 0;
            if ($urandom_range(1)) n.mass_2 = 0;
            if ($urandom_range(1)) n.mass_3 = 0;
        end
        return n;
    endfunction

    task automatic random_config();
        for (int i = 0; i < 4; i++)
            write_reg(i[IDX_W-1:0], $urandom_range(3) == 0 ? 32'd0 : 32'($urandom));
        case ($urandom_range(2))
            0: write_reg(REG_INV_TS, $urandom);
            1: write_reg(REG_INV_TS, $urandom_range(1 << 18));
            default: write_reg(REG_INV_TS, 32'hFFFF_FFFF);
        endcase
        write_reg(REG_ACTIVE, $urandom_range(7));
    endtask

    initial
    begin
        node_in_t n;
        int idle_mix [4];
        idle_mix = '{0, 72, 0, 31};
        for (int i = 0; i < SLOTS; i++) cp[i] = 16'd256;
        inv_ts = 32'd65536;
        active = 3'd4;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        pending_nodes.push_back('0);
        pending_nodes.push_back('1);
        n = '0; n.mass_0 = 16'hFFFF; n.temp_0 = 16'hFFFF; n.mass_1 = 16'h1; n.temp_1 = 16'h0;
        pending_nodes.push_back(n);
        n = '0; n.mass_0 = 16'h100; n.temp_0 = 16'd4800; n.mass_3 = 16'h100;
        n.temp_3 = 16'd4000;
        pending_nodes.push_back(n);
        n.temp_0 = 16'd4000; n.mass_1 = 16'h5; n.temp_1 = 16'hFFFF;
        pending_nodes.push_back(n);
        drain_results();

        write_reg(REG_INV_TS, 32'hFFFF_FFFF);
        write_reg(REG_HC0, 32'hFFFF);
        write_reg(REG_HC1, 32'h0);
        write_reg(REG_HC2, 32'h1);
        write_reg(REG_HC3, 32'hFFFF);
        n = '0; n.mass_0 = 16'hFFFF; n.temp_0 = 16'hFFFF; n.mass_3 = 16'hFFFF;
        pending_nodes.push_back(n);
        n.mass_1 = 16'hFFFF; n.mass_0 = 0; n.mass_3 = 0;
        pending_nodes.push_back(n);
        pending_nodes.push_back('1);
        pending_nodes.push_back({16'h1, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h1, 16'h2, 16'h3});
        drain_results();
        for (int a = 0; a < 8; a++)
        begin
            write_reg(REG_ACTIVE, a);
            pending_nodes.push_back({$urandom, $urandom, $urandom, $urandom});
            pending_nodes.push_back('1);
            drain_results();
        end
        write_reg(REG_INV_TS, 32'h0);
        pending_nodes.push_back({$urandom, $urandom, $urandom, $urandom});
        drain_results();

        for (int ph = 0; ph < 16; ph++)
        begin
            random_config();
            send_idle_pct = idle_mix[ph % 4];
            for (int k = 0; k < 125; k++)
                pending_nodes.push_back(random_node($urandom_range(4) < 3 ? 1 :
                                                   $urandom_range(2)));
            drain_results();
        end

        $display("Sent %0d nodes, checked %0d results over 16 random register settings,",
                 nodes_sent, results_seen);
        $display("including zero heat capacity, saturation and every active count.");
        if (errors == 0)
            $display("** thermal_contact_heat_exchange_top: PASSED **");
        else
            $display("** thermal_contact_heat_exchange_top: FAILED **");
        $finish;
    end
endmodule

// ===== thermal_contact_heat_exchange_top.f =====
sv/tche_pkg.sv
sv/tche_lane_front.sv
sv/tche_div.sv
sv/tche_lane_rate.sv
sv/thermal_contact_heat_exchange_top.sv
tb/tb.sv
